// File: src/lnm_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// lnm_pkg
// Shared types and constants of the lighting node metrics table.
// ============================================================================
package lnm_pkg;

    localparam int LNM_NODE_COUNT = 128;

    localparam int ADDR_W  = 7;
    localparam int TIME_W  = 32;
    localparam int LUX_W   = 24;
    localparam int DUTY_W  = 8;
    localparam int COUNT_W = 32;
    localparam int SUM_W   = 48;
    localparam int EN_W    = DUTY_W + TIME_W;   // duty * elapsed ms
    localparam int STEP_W  = LUX_W + 1;         // sum of two lux steps
    localparam int FLK_W   = STEP_W + 6;        // steps * 50

    localparam int unsigned FLICKER_GAIN = 50;

    // message kinds
    localparam logic [1:0] MODE_MEASURE   = 2'd0;
    localparam logic [1:0] MODE_CONSENSUS = 2'd1;
    localparam logic [1:0] MODE_NOISE     = 2'd2;

    typedef struct packed {
        logic [1:0]        mode;
        logic [ADDR_W-1:0] node_addr;
        logic [TIME_W-1:0] time_ms;
        logic [LUX_W-1:0]  lux_value;
        logic [LUX_W-1:0]  ref_value;
        logic [DUTY_W-1:0] duty;
    } msg_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  node_id;
        logic [COUNT_W-1:0] count_now;
        logic [SUM_W-1:0]   energy_total;
        logic [SUM_W-1:0]   flicker_total;
        logic [SUM_W-1:0]   error_total;
        logic [LUX_W-1:0]   control_level;
        logic [LUX_W-1:0]   reference_level;
        logic [LUX_W-1:0]   noise_level;
    } metrics_t;

    // one node record as held in the table memory
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  last_time;
        logic [DUTY_W-1:0]  last_duty;
        logic [LUX_W-1:0]   last_lux;
        logic [LUX_W-1:0]   older_lux;
        logic [SUM_W-1:0]   energy;
        logic [SUM_W-1:0]   flicker;
        logic [SUM_W-1:0]   error;
        logic [LUX_W-1:0]   ref_lux;
        logic [LUX_W-1:0]   control;
        logic [LUX_W-1:0]   noise;
    } record_t;

    // increments computed from the old record, added in the write-back cycle
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [EN_W-1:0]    energy;
        logic [FLK_W-1:0]   flicker;
        logic [LUX_W-1:0]   error;
    } terms_t;

    function automatic logic [SUM_W-1:0] add_sat(input logic [SUM_W-1:0] acc,
                                                 input logic [SUM_W-1:0] term);
        logic [SUM_W:0] sum;
        sum = {1'b0, acc} + {1'b0, term};
        return sum[SUM_W] ? {SUM_W{1'b1}} : sum[SUM_W-1:0];
    endfunction

    function automatic logic [LUX_W-1:0] abs_step(input logic [LUX_W-1:0] a,
                                                  input logic [LUX_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

// File: src/lnm_chan_if.sv
`timescale 1ns / 1ps
// ============================================================================
// lnm_chan_if
// Valid/ready channel carrying one word of a given payload type.
// ============================================================================
interface lnm_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/lnm_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// lnm_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ============================================================================
module lnm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/lighting_node_metrics_table_core.sv
`timescale 1ns / 1ps
// ============================================================================
// lighting_node_metrics_table_core
// Per-node metrics table: sample count, energy, flicker and comfort error.
// ============================================================================
// Usage:
//   msg     : sink channel, one decoded message word per handshake
//             (measurement, consensus result or noise level).
//   metrics : source channel, one word per message: the addressed record
//             after the update. An address at or beyond NODE_COUNT changes
//             nothing and reports zeros beside node_id.
//   Every record lives in one table RAM (NODE_COUNT deep, registered read).
//   A message is read, its terms computed, then the record is written back:
//   accept -> compute -> write-back, and the next message is accepted only
//   after write-back, as the table RAM is read, modified and written back
//   per message; the write lands before the next read is issued,
//   so back-to-back messages to the same node see the fresh record.
//   The result appears on metrics the cycle after write-back.
//   Reset: after rst_n releases, a clearing sweep writes zero into every
//   record, one per cycle; msg.ready stays low.
//   Stall: the output register holds a result while metrics.ready is low;
//   one further message is accepted and computed, and then waits in
//   write-back until the output register frees up.
// ============================================================================
module lighting_node_metrics_table_core #(
    parameter int NODE_COUNT = lnm_pkg::LNM_NODE_COUNT
) (
    input  logic clk,
    input  logic rst_n,
    lnm_chan_if.sink   msg,
    lnm_chan_if.source metrics
);

    localparam int AW = $clog2(NODE_COUNT);
    localparam int RW = $bits(lnm_pkg::record_t);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_CALC  = 2'd2;
    localparam logic [1:0] ST_WRITE = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [AW-1:0]       clr_idx_reg, clr_idx_next;

    lnm_pkg::msg_t       item_reg;
    logic                in_range_reg;
    lnm_pkg::terms_t     terms_reg, terms_next;
    lnm_pkg::metrics_t   metrics_reg, metrics_next;
    logic                out_valid_reg, out_valid_next;

    logic                accept;
    logic                out_free;
    logic                load_out;

    lnm_pkg::record_t    rec_old;
    lnm_pkg::record_t    rec_new;
    logic [RW-1:0]       ram_rdata;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [RW-1:0]       ram_wdata;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign msg.ready     = (state_reg == ST_IDLE);
    assign accept        = msg.valid && msg.ready;
    assign out_free      = !out_valid_reg || metrics.ready;
    assign load_out      = (state_reg == ST_WRITE) && out_free;
    assign metrics.valid = out_valid_reg;
    assign metrics.data  = metrics_reg;

    // ------------------------------------------------------------------
    // Table memory
    // ------------------------------------------------------------------
    lnm_ram #(
        .WIDTH (RW),
        .DEPTH (NODE_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (AW'(msg.data.node_addr)),
        .rdata (ram_rdata)
    );

    assign rec_old = lnm_pkg::record_t'(ram_rdata);

    // ------------------------------------------------------------------
    // Compute stage: increments from the old record (one 8x32 multiply,
    // one constant multiply by the flicker gain)
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [lnm_pkg::TIME_W-1:0] dt;
        logic                       turn;
        logic [lnm_pkg::STEP_W-1:0] steps;

        dt         = '0;
        turn       = 1'b0;
        steps      = '0;
        terms_next = terms_reg;
        if (state_reg == ST_CALC)
        begin
            terms_next.count = (rec_old.count == {lnm_pkg::COUNT_W{1'b1}})
                             ? rec_old.count : rec_old.count + 1'b1;

            dt = item_reg.time_ms - rec_old.last_time;
            if (terms_next.count >= 32'd2)
            begin
                terms_next.energy = lnm_pkg::EN_W'(rec_old.last_duty)
                                  * lnm_pkg::EN_W'(dt);
            end
            else
            begin
                terms_next.energy = '0;
            end

            // strict change of direction over the last three lux values
            turn = ((rec_old.older_lux < rec_old.last_lux)
                        && (rec_old.last_lux > item_reg.lux_value))
                || ((rec_old.older_lux > rec_old.last_lux)
                        && (rec_old.last_lux < item_reg.lux_value));
            steps = lnm_pkg::STEP_W'(lnm_pkg::abs_step(rec_old.older_lux,
                                                       rec_old.last_lux))
                  + lnm_pkg::STEP_W'(lnm_pkg::abs_step(rec_old.last_lux,
                                                       item_reg.lux_value));
            if ((terms_next.count > 32'd3) && turn)
            begin
                terms_next.flicker = lnm_pkg::FLK_W'(steps)
                                   * lnm_pkg::FLK_W'(lnm_pkg::FLICKER_GAIN);
            end
            else
            begin
                terms_next.flicker = '0;
            end

            terms_next.error = (rec_old.ref_lux > item_reg.lux_value)
                             ? rec_old.ref_lux - item_reg.lux_value : '0;
        end
    end

    // ------------------------------------------------------------------
    // Write-back stage: saturating sums and the new record
    // ------------------------------------------------------------------
    always_comb
    begin
        rec_new = rec_old;
        unique case (item_reg.mode)
            lnm_pkg::MODE_MEASURE:
            begin
                rec_new.count     = terms_reg.count;
                rec_new.energy    = lnm_pkg::add_sat(rec_old.energy,
                                        lnm_pkg::SUM_W'(terms_reg.energy));
                rec_new.flicker   = lnm_pkg::add_sat(rec_old.flicker,
                                        lnm_pkg::SUM_W'(terms_reg.flicker));
                rec_new.error     = lnm_pkg::add_sat(rec_old.error,
                                        lnm_pkg::SUM_W'(terms_reg.error));
                rec_new.older_lux = rec_old.last_lux;
                rec_new.last_lux  = item_reg.lux_value;
                rec_new.last_time = item_reg.time_ms;
                rec_new.last_duty = item_reg.duty;
            end
            lnm_pkg::MODE_CONSENSUS:
            begin
                rec_new.control = item_reg.lux_value;
                rec_new.ref_lux = item_reg.ref_value;
            end
            lnm_pkg::MODE_NOISE:
            begin
                rec_new.noise = item_reg.lux_value;
            end
            default:
            begin
                rec_new = rec_old;  // unused kind: record only reported
            end
        endcase
    end

    always_comb
    begin
        metrics_next = metrics_reg;
        if (load_out)
        begin
            metrics_next.node_id = item_reg.node_addr;
            if (in_range_reg)
            begin
                metrics_next.count_now       = rec_new.count;
                metrics_next.energy_total    = rec_new.energy;
                metrics_next.flicker_total   = rec_new.flicker;
                metrics_next.error_total     = rec_new.error;
                metrics_next.control_level   = rec_new.control;
                metrics_next.reference_level = rec_new.ref_lux;
                metrics_next.noise_level     = rec_new.noise;
            end
            else
            begin
                metrics_next.count_now       = '0;
                metrics_next.energy_total    = '0;
                metrics_next.flicker_total   = '0;
                metrics_next.error_total     = '0;
                metrics_next.control_level   = '0;
                metrics_next.reference_level = '0;
                metrics_next.noise_level     = '0;
            end
        end
    end

    // RAM write port: clearing sweep, or write-back of an in-range record
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_idx_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = load_out && in_range_reg;
            ram_waddr = AW'(item_reg.node_addr);
            ram_wdata = RW'(rec_new);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == AW'(NODE_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (metrics.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg     <= msg.data;
            in_range_reg <= (32'(msg.data.node_addr) < NODE_COUNT);
        end
        terms_reg   <= terms_next;
        metrics_reg <= metrics_next;
    end

endmodule

// File: src/lnm_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// lnm_checker
// Port-level checks of the metrics table, bound to the top level.
// ============================================================================
module lnm_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              msg_valid,
    input logic              msg_ready,
    input logic              metrics_valid,
    input logic              metrics_ready,
    input lnm_pkg::metrics_t metrics_data
);

    logic       msg_acc;
    logic       out_acc;
    logic [1:0] pending_reg, pending_next;

    assign msg_acc = msg_valid && msg_ready;
    assign out_acc = metrics_valid && metrics_ready;

    // messages accepted but not yet delivered
    always_comb
    begin
        pending_next = pending_reg + {1'b0, msg_acc} - {1'b0, out_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_no_orphan_result: assert property (@(posedge clk) disable iff (!rst_n)
        metrics_valid |-> (pending_reg != 2'd0))
        else $error("result shown with no message outstanding");

    a_bounded_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 2'd2)
        else $error("more than two messages outstanding");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        msg_acc |=> !msg_ready)
        else $error("message accepted while previous one still in the table");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (metrics_valid && !metrics_ready) |=> (metrics_valid && $stable(metrics_data)))
        else $error("stalled result dropped or changed");

endmodule

bind lighting_node_metrics_table_core lnm_checker u_lnm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .msg_valid     (msg.valid),
    .msg_ready     (msg.ready),
    .metrics_valid (metrics.valid),
    .metrics_ready (metrics.ready),
    .metrics_data  (metrics.data)
);

// File: test/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for lighting_node_metrics_table_core.
// ============================================================================
// Message words go in on the msg channel. For each accepted word, the bench
// computes the record it should produce from its own per-node state and
// queues it. A separate receive process stalls metrics.ready at random and
// checks each returned word field by field against the oldest queued record.
// The stimulus runs in three parts:
//   - short directed cases: field extremes, every message kind, the unused
//     kind, first sample and first noise message, time wrap, flat and
//     strict direction changes of lux
//   - a long run of measurements on one node, with near-full elapsed times
//     and full duty, back to back, until the energy sum saturates
//   - random traffic, mostly on a few busy nodes so records get deep, with
//     the idle pattern of both sides changing every hundred words
// ============================================================================
module testbench;

    localparam int         NODES       = lnm_pkg::LNM_NODE_COUNT;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         IDLE_MAX    = 18;
    localparam int         CYCLE_LIMIT = 500000;
    localparam int         DRAIN_WAIT  = 12;     // extra wait after the expected queue empties
    localparam int         SAT_WORDS   = 270;
    localparam int         RANDOM_WORDS = 1060;

    // bench copy of one node record
    typedef struct {
        bit [lnm_pkg::COUNT_W-1:0] count;
        bit [lnm_pkg::TIME_W-1:0]  last_time;
        bit [lnm_pkg::DUTY_W-1:0]  last_duty;
        bit [lnm_pkg::LUX_W-1:0]   last_lux;
        bit [lnm_pkg::LUX_W-1:0]   older_lux;
        bit [lnm_pkg::SUM_W-1:0]   energy;
        bit [lnm_pkg::SUM_W-1:0]   flicker;
        bit [lnm_pkg::SUM_W-1:0]   err_sum;
        bit [lnm_pkg::LUX_W-1:0]   ref_lvl;
        bit [lnm_pkg::LUX_W-1:0]   control;
        bit [lnm_pkg::LUX_W-1:0]   noise;
    } node_state_t;

    logic clk;
    logic rst_n;

    lnm_chan_if #(.payload_t(lnm_pkg::msg_t))     msg_ch ();
    lnm_chan_if #(.payload_t(lnm_pkg::metrics_t)) metrics_ch ();

    lighting_node_metrics_table_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .msg     (msg_ch),
        .metrics (metrics_ch)
    );

    node_state_t       node_tab [NODES];
    lnm_pkg::metrics_t expected_metrics [$];
    int                fail_count;
    int                cycle_count = 0;

    // idle ceilings per side; zero means no gaps at all
    int send_idle_max;
    int recv_idle_max;

    // busy nodes for random traffic
    bit [lnm_pkg::ADDR_W-1:0] busy_nodes [6] = '{7'd3, 7'd17, 7'd42, 7'd85, 7'd100, 7'd126};

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic bit [lnm_pkg::SUM_W-1:0] sum_clamped(
        input bit [lnm_pkg::SUM_W-1:0] acc,
        input bit [63:0]               term);
        bit [64:0] total;
        total = {17'b0, acc} + {1'b0, term};
        return (total > {17'b0, {lnm_pkg::SUM_W{1'b1}}}) ? {lnm_pkg::SUM_W{1'b1}}
                                                         : total[lnm_pkg::SUM_W-1:0];
    endfunction

    function automatic bit [63:0] lux_gap(input bit [lnm_pkg::LUX_W-1:0] a,
                                          input bit [lnm_pkg::LUX_W-1:0] b);
        return (a > b) ? 64'(a - b) : 64'(b - a);
    endfunction

    // Applies one message to the bench table and returns the record it reports.
    function automatic lnm_pkg::metrics_t predict_metrics(input lnm_pkg::msg_t m);
        lnm_pkg::metrics_t         rec;
        node_state_t               s;
        bit [lnm_pkg::TIME_W-1:0]  elapsed;
        bit [lnm_pkg::LUX_W-1:0]   lux;
        bit [lnm_pkg::LUX_W-1:0]   l2;
        bit [lnm_pkg::LUX_W-1:0]   l3;
        bit [63:0]                 steps;
        rec = '0;
        rec.node_id = m.node_addr;
        if (int'(m.node_addr) >= NODES)
            return rec;
        s   = node_tab[m.node_addr];
        lux = m.lux_value;
        case (m.mode)
            lnm_pkg::MODE_MEASURE:
            begin
                if (s.count != {lnm_pkg::COUNT_W{1'b1}})
                    s.count = s.count + 1;
                if (s.count >= 2)
                begin
                    elapsed  = m.time_ms - s.last_time;   // wraps modulo 2^32
                    s.energy = sum_clamped(s.energy, 64'(s.last_duty) * 64'(elapsed));
                end
                // flicker only on a strict turn of direction, fourth sample on
                if (s.count > 3)
                begin
                    l2 = s.last_lux;
                    l3 = s.older_lux;
                    if (((l3 < l2) && (l2 > lux)) || ((l3 > l2) && (l2 < lux)))
                    begin
                        steps     = lux_gap(l3, l2) + lux_gap(l2, lux);
                        s.flicker = sum_clamped(s.flicker,
                                                64'(lnm_pkg::FLICKER_GAIN) * steps);
                    end
                end
                if (s.ref_lvl > lux)
                    s.err_sum = sum_clamped(s.err_sum, 64'(s.ref_lvl - lux));
                s.older_lux = s.last_lux;
                s.last_lux  = lux;
                s.last_time = m.time_ms;
                s.last_duty = m.duty;
            end
            lnm_pkg::MODE_CONSENSUS:
            begin
                s.control = lux;
                s.ref_lvl = m.ref_value;
            end
            lnm_pkg::MODE_NOISE:
            begin
                s.noise = lux;
            end
            default:
            begin
            end
        endcase
        node_tab[m.node_addr] = s;
        rec.count_now       = s.count;
        rec.energy_total    = s.energy;
        rec.flicker_total   = s.flicker;
        rec.error_total     = s.err_sum;
        rec.control_level   = s.control;
        rec.reference_level = s.ref_lvl;
        rec.noise_level     = s.noise;
        return rec;
    endfunction

    // ------------------------------------------------------------------------
    // Send side
    // ------------------------------------------------------------------------
    function automatic lnm_pkg::msg_t make_msg(input logic [1:0] mode,
                                               input logic [lnm_pkg::ADDR_W-1:0] addr,
                                               input logic [lnm_pkg::TIME_W-1:0] t,
                                               input logic [lnm_pkg::LUX_W-1:0] lux,
                                               input logic [lnm_pkg::LUX_W-1:0] refv,
                                               input logic [lnm_pkg::DUTY_W-1:0] duty);
        lnm_pkg::msg_t m;
        m.mode      = mode;
        m.node_addr = addr;
        m.time_ms   = t;
        m.lux_value = lux;
        m.ref_value = refv;
        m.duty      = duty;
        return m;
    endfunction

    // Presents one word after a random gap and holds it until accepted.
    task automatic send_message(input lnm_pkg::msg_t m);
        int gap;
        gap = (send_idle_max == 0) ? 0 : $urandom_range(0, send_idle_max);
        if (gap > 0)
        begin
            msg_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        msg_ch.data  <= m;
        msg_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!msg_ch.ready);
        expected_metrics = {expected_metrics, predict_metrics(m)};
    endtask

    // ------------------------------------------------------------------------
    // Receive side: random stalls, field-by-field check
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    initial
    begin
        int                stall;
        lnm_pkg::metrics_t got;
        lnm_pkg::metrics_t want;
        metrics_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = (recv_idle_max == 0) ? 0 : $urandom_range(0, recv_idle_max);
            if (stall > 0)
            begin
                metrics_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            metrics_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!metrics_ch.valid);
            got = metrics_ch.data;
            if (expected_metrics.size() == 0)
            begin
                $error("result word for node %0d with none expected", got.node_id);
                fail_count++;
            end
            else
            begin
                want = expected_metrics.pop_front();
                check_field("node_id",         64'(want.node_id),
                                               64'(got.node_id));
                check_field("count_now",       64'(want.count_now),
                                               64'(got.count_now));
                check_field("energy_total",    64'(want.energy_total),
                                               64'(got.energy_total));
                check_field("flicker_total",   64'(want.flicker_total),
                                               64'(got.flicker_total));
                check_field("error_total",     64'(want.error_total),
                                               64'(got.error_total));
                check_field("control_level",   64'(want.control_level),
                                               64'(got.control_level));
                check_field("reference_level", 64'(want.reference_level),
                                               64'(got.reference_level));
                check_field("noise_level",     64'(want.noise_level),
                                               64'(got.noise_level));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Hand-picked words: extremes, every kind, first-time cases, lux turns.
    task automatic test_directed_cases();
        // node 0: first sample before any consensus, so no shortfall yet
        send_message(make_msg(lnm_pkg::MODE_MEASURE,   7'd0, 32'h0000_0000,
                              24'h000000, 24'hFFFFFF, 8'h00));
        // first noise word of a node keeps its value
        send_message(make_msg(lnm_pkg::MODE_NOISE,     7'd0, 32'hFFFF_FFFF,
                              24'hFFFFFF, 24'h000000, 8'hFF));
        send_message(make_msg(lnm_pkg::MODE_CONSENSUS, 7'd0, 32'h0000_0000,
                              24'hFFFFFF, 24'hFFFFFF, 8'h00));
        // full shortfall; previous duty zero gives no energy
        send_message(make_msg(lnm_pkg::MODE_MEASURE,   7'd0, 32'hFFFF_FFFF,
                              24'h000000, 24'h000000, 8'hFF));
        // time wraps: elapsed 0x11 at duty 0xFF
        send_message(make_msg(lnm_pkg::MODE_MEASURE,   7'd0, 32'h0000_0010,
                              24'hFFFFFF, 24'h000000, 8'h80));
        // fourth sample, rise then fall across the full range
        send_message(make_msg(lnm_pkg::MODE_MEASURE,   7'd0, 32'h0000_0020,
                              24'h000000, 24'h000000, 8'h01));
        // fall then flat: not a strict turn
        send_message(make_msg(lnm_pkg::MODE_MEASURE,   7'd0, 32'h0000_0030,
                              24'h000000, 24'h000000, 8'h7F));
        // flat then rise: no turn either
        send_message(make_msg(lnm_pkg::MODE_MEASURE,   7'd0, 32'h0000_0040,
                              24'h000100, 24'h000000, 8'h00));
        // rise then fall, small steps
        send_message(make_msg(lnm_pkg::MODE_MEASURE,   7'd0, 32'h0000_0050,
                              24'h000000, 24'h000000, 8'hFF));
        // fall then rise
        send_message(make_msg(lnm_pkg::MODE_MEASURE,   7'd0, 32'h0000_0060,
                              24'h000080, 24'h000000, 8'hAA));
        // unused kind: record reported, nothing changes
        send_message(make_msg(MODE_UNUSED,             7'd0, 32'hFFFF_FFFF,
                              24'hFFFFFF, 24'hFFFFFF, 8'hFF));
        send_message(make_msg(MODE_UNUSED,             7'd9, 32'h5555_5555,
                              24'h555555, 24'hAAAAAA, 8'h55));
        // node 127: reference first, then first sample below it
        send_message(make_msg(lnm_pkg::MODE_CONSENSUS, 7'd127, 32'hAAAA_AAAA,
                              24'h000000, 24'h001234, 8'hAA));
        send_message(make_msg(lnm_pkg::MODE_MEASURE,   7'd127, 32'h1234_5678,
                              24'h001000, 24'hFFFFFF, 8'hFF));
        send_message(make_msg(lnm_pkg::MODE_NOISE,     7'd127, 32'h0000_0000,
                              24'h000000, 24'h000000, 8'h00));
        send_message(make_msg(lnm_pkg::MODE_NOISE,     7'd127, 32'h0000_0000,
                              24'hABCDEF, 24'h000000, 8'h00));
        send_message(make_msg(lnm_pkg::MODE_MEASURE,   7'd127, 32'hFFFF_FFFF,
                              24'hFFFFFF, 24'h000000, 8'hFF));
        // full duty over a wrap of one ms
        send_message(make_msg(lnm_pkg::MODE_MEASURE,   7'd127, 32'h0000_0000,
                              24'h001233, 24'h000000, 8'h00));
        // reference equal to lux: no shortfall
        send_message(make_msg(lnm_pkg::MODE_CONSENSUS, 7'd64, 32'h0F0F_0F0F,
                              24'h555555, 24'hAAAAAA, 8'h0F));
        send_message(make_msg(lnm_pkg::MODE_MEASURE,   7'd64, 32'hF0F0_F0F0,
                              24'hAAAAAA, 24'h555555, 8'hF0));
    endtask

    // Long back-to-back run on one node: full duty, near-full elapsed time,
    // enough words to drive the energy sum into saturation and keep it there.
    task automatic test_energy_saturation();
        bit [lnm_pkg::TIME_W-1:0] t;
        bit [lnm_pkg::LUX_W-1:0]  lux;
        send_idle_max = 0;
        recv_idle_max = 0;
        t   = $urandom;
        lux = lnm_pkg::LUX_W'($urandom);
        for (int i = 0; i < SAT_WORDS; i++)
        begin
            t   = t + 32'hFFFF_0000 + $urandom_range(0, 16'hFFFF);
            lux = lnm_pkg::LUX_W'(lux + $urandom_range(0, 2047) - 1024);
            send_message(make_msg(lnm_pkg::MODE_MEASURE, 7'd77, t, lux,
                                  lnm_pkg::LUX_W'($urandom), 8'hFF));
            // let the output side stall for the second half
            if (i == SAT_WORDS / 2)
                recv_idle_max = IDLE_MAX;
        end
        send_idle_max = IDLE_MAX;
    endtask

    // Random traffic, mostly well-formed sample streams on a few busy nodes.
    task automatic test_random_traffic();
        lnm_pkg::msg_t            m;
        int                       pick;
        int                       regime;
        bit [lnm_pkg::ADDR_W-1:0] addr;
        node_state_t              s;
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            // new idle pattern every hundred words, including no gaps at all
            if (i % 100 == 0)
            begin
                regime        = $urandom_range(0, 3);
                send_idle_max = (regime[0]) ? 0 : IDLE_MAX;
                recv_idle_max = (regime[1]) ? 0 : IDLE_MAX;
            end
            addr = ($urandom_range(0, 99) < 80) ? busy_nodes[$urandom_range(0, 5)]
                                                : 7'($urandom_range(0, NODES - 1));
            s    = node_tab[addr];
            m    = make_msg(lnm_pkg::MODE_MEASURE, addr, $urandom,
                            lnm_pkg::LUX_W'($urandom), lnm_pkg::LUX_W'($urandom),
                            lnm_pkg::DUTY_W'($urandom));
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                // sample stream: small lux walk gives frequent turns
                if ($urandom_range(0, 99) < 75)
                    m.lux_value = lnm_pkg::LUX_W'(s.last_lux
                                                  + $urandom_range(0, 2047) - 1024);
                if ($urandom_range(0, 99) < 85)
                    m.time_ms = s.last_time + $urandom_range(0, 60000);
            end
            else if (pick < 82)
            begin
                m.mode = lnm_pkg::MODE_CONSENSUS;
                // reference near the current lux so shortfalls come and go
                if ($urandom_range(0, 1) == 1)
                    m.ref_value = lnm_pkg::LUX_W'(s.last_lux + $urandom_range(0, 4095));
            end
            else if (pick < 94)
                m.mode = lnm_pkg::MODE_NOISE;
            else
                m.mode = MODE_UNUSED;
            send_message(m);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        fail_count    = 0;
        send_idle_max = IDLE_MAX;
        recv_idle_max = IDLE_MAX;
        foreach (node_tab[n])
            node_tab[n] = '{default: '0};
        rst_n        <= 1'b0;
        msg_ch.valid <= 1'b0;
        msg_ch.data  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // msg.ready stays low through the clearing sweep; send waits on it
        test_directed_cases();
        test_energy_saturation();
        test_random_traffic();

        msg_ch.valid <= 1'b0;
        while (expected_metrics.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
src/lnm_pkg.sv
src/lnm_chan_if.sv
src/lnm_ram.sv
src/lighting_node_metrics_table_core.sv
src/lnm_checker.sv
test/testbench.sv
